// ===== rtl/core/arpc_pkg.sv =====
// Package for the ARP cache: sizes, command and state codes, and the request,
// response and internal job records shared by every module of the block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package arpc_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    localparam int IP_W  = 32;
    localparam int MAC_W = 48;

    localparam logic [IP_W-1:0] OWN_ADDR_RESET = 32'hAC10060F;

    typedef enum logic {
        CMD_LOOKUP = 1'b0,
        CMD_LEARN  = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } t_back_state;

    typedef struct packed {
        t_cmd             cmd;
        logic [IP_W-1:0]  peer_address;
        logic [MAC_W-1:0] peer_mac;
        logic             is_request;
        logic [IP_W-1:0]  target_address;
    } t_req;

    typedef struct packed {
        logic             hit;
        logic [MAC_W-1:0] found_mac;
        logic             added_new;
        logic             dropped_full;
        logic             reply_due;
    } t_rsp;

    // A classified request as it waits in the queue between front and back.
    typedef struct packed {
        t_cmd             cmd;
        logic [IP_W-1:0]  peer_address;
        logic [MAC_W-1:0] peer_mac;
        logic             reply_due;
    } t_job;

    // Job with a valid flag, passed from the front to the queue and from the queue to the back end.
    typedef struct packed {
        logic valid;
        t_job job;
    } t_job_slot;

endpackage

`default_nettype wire

// ===== rtl/core/arpc_if.sv =====
// Valid/ready channel interfaces for requests and responses of the ARP cache.
// Depends on arpc_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface arpc_req_if
    import arpc_pkg::*;
();
    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface arpc_rsp_if
    import arpc_pkg::*;
();
    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/arp_cache_learn_lookup.sv =====
// ARP cache with up to 16 IPv4-to-MAC entries, filled in arrival order and never
// evicted. Lookup requests return the MAC of the lowest matching entry; learn
// requests update a known sender, append an unknown one or flag it as dropped
// when the table is full, and report whether an ARP reply is owed. Each request
// gives exactly one response. In the back end a request passes an idle/load
// state, a scan of the filled entries that ends at the first match, and an
// update state; the scan reads one entry per cycle through the single read port
// of each entry memory and is skipped when the table is empty. A two-entry queue
// and a response register let requests and responses stall independently.
// Write the own address only while no request is in flight.
`timescale 1ns / 1ps
`default_nettype none

module arp_cache_learn_lookup
    import arpc_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    arpc_req_if.sink             i_req,
    arpc_rsp_if.source           o_rsp,
    input  wire logic            i_cfg_we,
    input  wire logic [IP_W-1:0] i_cfg_wdata
);

    t_job_slot push;
    t_job_slot head;
    logic      push_ready;
    logic      pop;

    arpc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (i_req),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_push_ready (push_ready),
        .o_push       (push)
    );

    arpc_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_push_ready (push_ready),
        .o_head       (head),
        .i_pop        (pop)
    );

    arpc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_rsp   (o_rsp)
    );

endmodule

`default_nettype wire

// ===== rtl/core/arpc_front.sv =====
// Front end of the ARP cache: holds the own-address register, accepts
// requests and classifies them into jobs for the queue.
// Depends on arpc_pkg and arpc_if.
`timescale 1ns / 1ps
`default_nettype none

module arpc_front
    import arpc_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    arpc_req_if.sink             i_req,
    input  wire logic            i_cfg_we,
    input  wire logic [IP_W-1:0] i_cfg_wdata,
    input  wire logic            i_push_ready,
    output t_job_slot            o_push
);

    logic [IP_W-1:0] r_own_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_addr <= OWN_ADDR_RESET;
        end else if (i_cfg_we) begin
            r_own_addr <= i_cfg_wdata;
        end
    end

    // The reply decision only needs the request fields and the own address,
    // so it is made here and the back end never sees the target address.
    always_comb begin
        o_push.valid            = i_req.valid;
        o_push.job.cmd          = i_req.data.cmd;
        o_push.job.peer_address = i_req.data.peer_address;
        o_push.job.peer_mac     = i_req.data.peer_mac;
        o_push.job.reply_due    = (i_req.data.cmd == CMD_LEARN) && i_req.data.is_request
                                  && (i_req.data.target_address == r_own_addr);
    end

    assign i_req.ready = i_push_ready;

endmodule

`default_nettype wire

// ===== rtl/core/arpc_queue.sv =====
// Two-entry job queue that decouples the ARP cache front end from the back end.
// Depends on arpc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module arpc_queue
    import arpc_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_job_slot i_push,
    output logic           o_push_ready,
    output t_job_slot      o_head,
    input  wire logic      i_pop
);

    t_job       r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_push_ready = (r_count != 2'd2);
    assign do_push      = i_push.valid && o_push_ready;
    assign do_pop       = i_pop && (r_count != 2'd0);

    assign o_head.valid = (r_count != 2'd0);
    assign o_head.job   = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 2'd1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_push.job;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/arpc_back.sv =====
// Back end of the ARP cache: the entry memories, the fill count, the scan
// sequencer and the response register.
// Depends on arpc_pkg and arpc_if.
`timescale 1ns / 1ps
`default_nettype none

module arpc_back
    import arpc_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_job_slot i_head,
    output logic           o_pop,
    arpc_rsp_if.source     o_rsp
);

    logic [IP_W-1:0]  mem_addr [ENTRIES];
    logic [MAC_W-1:0] mem_mac  [ENTRIES];

    t_back_state      r_state, n_state;
    t_job             r_job, n_job;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic             r_issue, n_issue;
    logic             r_rd_vld;
    logic [IDX_W-1:0] r_rd_idx;
    logic [IP_W-1:0]  r_rd_addr;
    logic [MAC_W-1:0] r_rd_mac;
    logic             r_hit, n_hit;
    logic [IDX_W-1:0] r_hit_idx, n_hit_idx;
    logic [MAC_W-1:0] r_hit_mac, n_hit_mac;
    logic [CNT_W-1:0] r_fill, n_fill;
    logic             r_out_vld, n_out_vld;
    t_rsp             r_out, n_out;

    logic             rd_match;
    logic             rd_last;
    logic             out_free;
    logic             wr_addr_en;
    logic             wr_mac_en;
    logic [IDX_W-1:0] wr_idx;

    assign rd_match = r_rd_vld && (r_rd_addr == r_job.peer_address);
    assign rd_last  = r_rd_vld && ((CNT_W'(r_rd_idx) + CNT_W'(1)) == r_fill);
    assign out_free = !r_out_vld || o_rsp.ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_head.valid) begin
                    n_state = (r_fill == '0) ? ST_UPDATE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (rd_match || rd_last) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_pop      = 1'b0;
        n_job      = r_job;
        n_idx      = r_idx;
        n_issue    = r_issue;
        n_hit      = r_hit;
        n_hit_idx  = r_hit_idx;
        n_hit_mac  = r_hit_mac;
        n_fill     = r_fill;
        n_out_vld  = r_out_vld && !o_rsp.ready;
        n_out      = r_out;
        wr_addr_en = 1'b0;
        wr_mac_en  = 1'b0;
        wr_idx     = r_fill[IDX_W-1:0];
        case (r_state)
            ST_IDLE: begin
                o_pop = 1'b1;
                if (i_head.valid) begin
                    n_job   = i_head.job;
                    n_idx   = '0;
                    n_issue = (r_fill != '0);
                    n_hit   = 1'b0;
                end
            end
            ST_SCAN: begin
                // Reads are issued one entry a cycle; each compare happens in the next
                // cycle on the registered read data, lowest index first.
                if (r_issue) begin
                    n_idx   = r_idx + CNT_W'(1);
                    n_issue = (r_idx + CNT_W'(1)) < r_fill;
                end
                if (rd_match) begin
                    n_hit     = 1'b1;
                    n_hit_idx = r_rd_idx;
                    n_hit_mac = r_rd_mac;
                    n_issue   = 1'b0;
                end
            end
            ST_UPDATE: begin
                if (out_free) begin
                    n_out_vld          = 1'b1;
                    n_out.hit          = r_hit;
                    n_out.found_mac    = '0;
                    n_out.added_new    = 1'b0;
                    n_out.dropped_full = 1'b0;
                    n_out.reply_due    = r_job.reply_due;
                    if (r_job.cmd == CMD_LOOKUP) begin
                        if (r_hit) begin
                            n_out.found_mac = r_hit_mac;
                        end
                    end else if (r_hit) begin
                        wr_mac_en = 1'b1;
                        wr_idx    = r_hit_idx;
                    end else if (r_fill < CNT_W'(ENTRIES)) begin
                        wr_addr_en      = 1'b1;
                        wr_mac_en       = 1'b1;
                        n_fill          = r_fill + CNT_W'(1);
                        n_out.added_new = 1'b1;
                    end else begin
                        n_out.dropped_full = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_issue   <= 1'b0;
            r_rd_vld  <= 1'b0;
            r_hit     <= 1'b0;
            r_fill    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_issue   <= n_issue;
            r_rd_vld  <= (r_state == ST_SCAN) && r_issue;
            r_hit     <= n_hit;
            r_fill    <= n_fill;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job     <= n_job;
        r_idx     <= n_idx;
        r_rd_idx  <= r_idx[IDX_W-1:0];
        r_hit_idx <= n_hit_idx;
        r_hit_mac <= n_hit_mac;
        r_out     <= n_out;
    end

    // Entry memories: one write port, one registered read port each.
    always_ff @(posedge i_clk) begin
        if (wr_addr_en) begin
            mem_addr[wr_idx] <= r_job.peer_address;
        end
        r_rd_addr <= mem_addr[r_idx[IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (wr_mac_en) begin
            mem_mac[wr_idx] <= r_job.peer_mac;
        end
        r_rd_mac <= mem_mac[r_idx[IDX_W-1:0]];
    end

    assign o_rsp.valid = r_out_vld;
    assign o_rsp.data  = r_out;

endmodule

`default_nettype wire

// ===== rtl/core/arpc_checker.sv =====
// Port-level checks for the ARP cache response channel, bound to the top level.
// Depends on arpc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module arpc_checker
    import arpc_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_rsp_valid,
    input wire logic i_rsp_ready,
    input wire t_rsp i_rsp_data
);

    // A response that is not taken must stay up with the same contents.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_data))
        else $error("response changed or dropped while stalled");

    // The block comes out of reset with no response pending.
    a_rsp_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_rsp_valid)
        else $error("response valid right after reset");

    // A returned MAC only comes from a lookup hit, which never adds, drops or owes a reply.
    a_mac_on_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_rsp_data.found_mac != '0)
        |-> i_rsp_data.hit && !i_rsp_data.added_new && !i_rsp_data.dropped_full
            && !i_rsp_data.reply_due)
        else $error("found MAC reported without a lookup hit");

    // Hit, append and drop are mutually exclusive outcomes.
    a_outcome: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |->
            $onehot0({i_rsp_data.hit, i_rsp_data.added_new, i_rsp_data.dropped_full}))
        else $error("more than one learn outcome flagged");

endmodule

bind arp_cache_learn_lookup arpc_checker u_arpc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_data  (o_rsp.data)
);

`default_nettype wire
